@@ src/ss_pkg.sv @@
// ----------------------------------------------------------------------------
// ss_pkg
// Shared constants for the selection sort min-extract block: default store
// depth, default stored value width and the fixed width of the value ports.
// ----------------------------------------------------------------------------
package ss_pkg;

	// default number of store entries
	localparam int SS_CAPACITY   = 32;
	// default width of a stored value
	localparam int SS_VALUE_BITS = 16;
	// width of the value and sorted_value ports
	localparam int SS_PORT_BITS  = 16;

endpackage

@@ src/selection_sort_min_extract_top.sv @@
// ----------------------------------------------------------------------------
// selection_sort_min_extract_top
// Collects unsigned values into a RAM; on the request flagged final_item it
// emits every held value in ascending order (ties to the lowest entry), the
// last one flagged run_end. Values beyond the store depth are dropped.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------
//  item    | item_valid / item_stall   | value, final_item
//  result  | result_valid / result_stall | sorted_value, run_end
//
//  loading takes one request per cycle, one RAM write each while the store has room.
//  after the final request a run of n values takes n passes: n RAM reads
//  through the single read port, the wait for the last read data, a step to
//  close the pass and an emit step; item_stall is high for the whole run.
//  a held result waits in the output register; a stalled result holds the
//  emit step until the register frees.
//  reset clears the count, the used bits and both valids; RAM is not cleared.
// ----------------------------------------------------------------------------
module selection_sort_min_extract_top #(
	parameter int CAPACITY   = ss_pkg::SS_CAPACITY,
	parameter int VALUE_BITS = ss_pkg::SS_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [ss_pkg::SS_PORT_BITS-1:0] value,
	input  logic                            final_item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [ss_pkg::SS_PORT_BITS-1:0] sorted_value,
	output logic                            run_end
);
	import ss_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           rd_idx_q;
	logic [CW-1:0]           emitted_q;
	logic                    valid_s1;
	logic [IW-1:0]           idx_s1;
	logic                    found_q;
	logic [VALUE_BITS-1:0]   best_q;
	logic [IW-1:0]           pick_q;
	logic [CAPACITY-1:0]     used_q;
	logic                    out_valid_q;
	logic [SS_PORT_BITS-1:0] out_value_q;
	logic                    out_end_q;

	logic                           accept;
	logic                           ram_we;
	logic [VALUE_BITS+SS_PORT_BITS-1:0] in_ext;
	logic [VALUE_BITS-1:0]          in_val;
	logic [VALUE_BITS-1:0]          rdata;
	logic [VALUE_BITS+SS_PORT_BITS-1:0] out_ext;
	logic                           issue;
	logic                           take;
	logic                           better;
	logic                           out_free;
	logic                           emit;
	logic                           last_pass;

	// value store
	ss_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(in_val),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(rdata)
	);

	// request side and width fitting
	always_comb begin
		accept    = item_valid && !item_stall;
		ram_we    = accept && (cnt_q < CW'(CAPACITY));
		in_ext    = {{VALUE_BITS{1'b0}}, value};
		in_val    = in_ext[VALUE_BITS-1:0];
		out_ext   = {{SS_PORT_BITS{1'b0}}, best_q};
		issue     = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
		take      = valid_s1 && !used_q[idx_s1];
		better    = !found_q || (rdata < best_q);
		out_free  = !out_valid_q || !result_stall;
		emit      = (state_q == ST_EMIT) && out_free;
		last_pass = (CW'(emitted_q + 1'b1) == cnt_q);
	end

	assign item_stall   = (state_q != ST_LOAD);
	assign result_valid = out_valid_q;
	assign sorted_value = out_value_q;
	assign run_end      = out_end_q;

	// sequencer: load, scan passes, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			emitted_q   <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_end_q   <= 1'b0;
		end else begin
			// output register drains
			if (out_valid_q && !result_stall && !emit) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline stage
			valid_s1 <= issue;
			idx_s1   <= rd_idx_q[IW-1:0];

			// running minimum over the returned entries
			if (take && better) begin
				found_q <= 1'b1;
				best_q  <= rdata;
				pick_q  <= idx_s1;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (ram_we) begin
						cnt_q <= CW'(cnt_q + 1'b1);
					end
					if (accept && final_item) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= CW'(rd_idx_q + 1'b1);
					end else if (!valid_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						out_valid_q     <= 1'b1;
						out_value_q     <= out_ext[SS_PORT_BITS-1:0];
						out_end_q       <= last_pass;
						rd_idx_q        <= '0;
						found_q         <= 1'b0;
						if (last_pass) begin
							// run finished: store empty again
							state_q   <= ST_LOAD;
							cnt_q     <= '0;
							emitted_q <= '0;
							used_q    <= '0;
						end else begin
							used_q[pick_q] <= 1'b1;
							emitted_q      <= CW'(emitted_q + 1'b1);
							state_q        <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ src/ss_ram.sv @@
// ----------------------------------------------------------------------------
// ss_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/ss_checker.sv @@
// ----------------------------------------------------------------------------
// ss_checker
// Port-level checks for the selection sort block: result channel holding
// and the load/sort switching seen on item_stall. Bound to the top level.
// ----------------------------------------------------------------------------
module ss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input logic                            final_item,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [ss_pkg::SS_PORT_BITS-1:0] sorted_value,
	input logic                            run_end
);
	import ss_pkg::*;

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(sorted_value) && $stable(run_end))
		else $error("result payload changed while stalled");

	// the final request closes loading
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && final_item |=> item_stall)
		else $error("request taken right after final request");

	// loading carries on after a non-final request
	a_load_continues: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !final_item |=> !item_stall)
		else $error("stall raised after non-final request");

endmodule

bind selection_sort_min_extract_top ss_checker u_ss_checker (.*);
